// ----- hdl/rde_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radix digit emitter package
// Widths, register reset values and the configuration bundle that the
// register file hands to the conversion datapath.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int SYMBOL_BITS = 8;
    localparam int DIGIT_BITS  = 4;
    localparam int RADIX_BITS  = 5;
    localparam int CHUNK_BITS  = 8;
    localparam int DATA_BITS   = 64;
    localparam int ADDR_BITS   = 5;
    localparam int TABLE_BITS  = 16 * SYMBOL_BITS;

    // Register indexes; each register sits on an 8-byte boundary.
    localparam logic [1:0] REG_RADIX        = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET        = 5'd10;
    localparam logic [DATA_BITS-1:0]  SYMBOLS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [DATA_BITS-1:0]  SYMBOLS_HIGH_RESET = 64'h6665646362613938;

    typedef struct packed {
        logic [RADIX_BITS-1:0] radix;
        logic [TABLE_BITS-1:0] symbols;
    } cfg_t;

endpackage
`default_nettype wire

// ----- hdl/rde_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radix digit emitter register file
// APB-style register port holding the radix and the two halves of the digit
// symbol table; presents the clamped radix and the table to the datapath.
// ----------------------------------------------------------------------------
module rde_cfg #(
    parameter int MAX_RADIX = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rde_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [rde_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [rde_pkg::DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output rde_pkg::cfg_t                       cfg
);

    import rde_pkg::*;

    logic [RADIX_BITS-1:0] radix_reg;
    logic [DATA_BITS-1:0]  symbols_low_reg;
    logic [DATA_BITS-1:0]  symbols_high_reg;
    logic [1:0]            reg_index;
    logic                  wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_BITS-1:3];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= RADIX_RESET;
            symbols_low_reg  <= SYMBOLS_LOW_RESET;
            symbols_high_reg <= SYMBOLS_HIGH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_RADIX:        radix_reg        <= pwdata[RADIX_BITS-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= pwdata;
                REG_SYMBOLS_HIGH: symbols_high_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_RADIX:        prdata = DATA_BITS'(radix_reg);
            REG_SYMBOLS_LOW:  prdata = symbols_low_reg;
            REG_SYMBOLS_HIGH: prdata = symbols_high_reg;
            default:          prdata = '0;
        endcase
    end

    // Out-of-range radix values are pulled back into the supported range.
    always_comb
    begin
        priority if (radix_reg < RADIX_BITS'(2))
            cfg.radix = RADIX_BITS'(2);
        else if (radix_reg > RADIX_BITS'(MAX_RADIX))
            cfg.radix = RADIX_BITS'(MAX_RADIX);
        else
            cfg.radix = radix_reg;
        cfg.symbols = {symbols_high_reg, symbols_low_reg};
    end

endmodule
`default_nettype wire

// ----- hdl/rde_div_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radix digit emitter divide step
// Divides one byte of the running quotient, prefixed by the remainder carried
// from the byte above, by the radix: one restoring step per bit.
// ----------------------------------------------------------------------------
module rde_div_step (
    input  wire logic [rde_pkg::DIGIT_BITS-1:0] rem_in,
    input  wire logic [rde_pkg::CHUNK_BITS-1:0] chunk,
    input  wire logic [rde_pkg::RADIX_BITS-1:0] divisor,
    output logic      [rde_pkg::CHUNK_BITS-1:0] quot,
    output logic      [rde_pkg::DIGIT_BITS-1:0] rem_out
);

    import rde_pkg::*;

    logic [DIGIT_BITS:0] part;

    // The partial remainder stays below the divisor, so it fits a digit.
    always_comb
    begin
        part = {1'b0, rem_in};
        quot = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--)
        begin
            part = {part[DIGIT_BITS-1:0], chunk[i]};
            if (part >= divisor)
            begin
                part    = part - divisor;
                quot[i] = 1'b1;
            end
        end
        rem_out = part[DIGIT_BITS-1:0];
    end

endmodule
`default_nettype wire

// ----- hdl/radix_digit_emitter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radix digit emitter
// Converts an unsigned value to characters in a base from 2 to 16,
// most significant digit first, the last character flagged.
// ----------------------------------------------------------------------------
// One value is converted at a time; item_stall stays high from the accepted
// beat until the last character has been taken. The value is divided by the
// radix repeatedly in a single byte-wide divide unit, one byte of the running
// quotient per cycle, starting from the highest byte still in use; each full
// pass yields one digit, which goes into a small digit memory. A pass covers
// only the live bytes of the quotient (at most ceil(VALUE_BITS/8)), so passes
// grow shorter as the value shrinks. The digits are then read back in
// reverse, each character held while the sink stalls. A zero value gives one
// character.
// ----------------------------------------------------------------------------
module radix_digit_emitter #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_RADIX  = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rde_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [rde_pkg::DATA_BITS-1:0]   pwdata,
    output logic      [rde_pkg::DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic [rde_pkg::VALUE_WIDTH-1:0] value,
    output logic                                 digit_valid,
    input  wire logic                            digit_stall,
    output logic      [rde_pkg::SYMBOL_BITS-1:0] symbol,
    output logic                                 final_digit
);

    import rde_pkg::*;

    localparam int W        = ((VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS) * CHUNK_BITS;
    localparam int NCH      = W / CHUNK_BITS;
    localparam int IDX_BITS = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int LEN_BITS = $clog2(NCH + 1);
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
    localparam int ADR_BITS = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT_READ,
        ST_EMIT_SHOW
    } state_t;

    cfg_t                  cfg;
    state_t                state_reg, state_next;
    logic [W-1:0]          n_reg, n_next;
    logic [DIGIT_BITS-1:0] rem_reg, rem_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [ADR_BITS-1:0]   ptr_reg, ptr_next;
    logic                  qnz_reg, qnz_next;
    logic [DIGIT_BITS-1:0] rd_digit_reg;
    logic [DIGIT_BITS-1:0] digit_mem [VALUE_BITS];

    logic [CHUNK_BITS-1:0] chunk;
    logic [CHUNK_BITS-1:0] quot;
    logic [DIGIT_BITS-1:0] rem_out;
    logic [IDX_BITS-1:0]   top_idx;
    logic                  item_take;
    logic                  pass_end;
    logic                  mem_we;

    rde_cfg #(
        .MAX_RADIX (MAX_RADIX)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign chunk = n_reg[idx_reg*CHUNK_BITS +: CHUNK_BITS];

    rde_div_step u_div (
        .rem_in  (rem_reg),
        .chunk   (chunk),
        .divisor (cfg.radix),
        .quot    (quot),
        .rem_out (rem_out)
    );

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_take   = item_valid && !item_stall;
    assign digit_valid = (state_reg == ST_EMIT_SHOW);
    assign final_digit = (ptr_reg == '0);
    assign symbol      = cfg.symbols[rd_digit_reg*SYMBOL_BITS +: SYMBOL_BITS];
    assign top_idx     = IDX_BITS'(len_reg - LEN_BITS'(1));
    assign pass_end    = (idx_reg == '0);
    assign mem_we      = (state_reg == ST_DIVIDE) && pass_end;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        qnz_next   = qnz_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    n_next     = W'(value[VALUE_BITS-1:0]);
                    rem_next   = '0;
                    idx_next   = IDX_BITS'(NCH - 1);
                    len_next   = LEN_BITS'(NCH);
                    count_next = '0;
                    qnz_next   = 1'b0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                n_next[idx_reg*CHUNK_BITS +: CHUNK_BITS] = quot;
                // Dividing by at most 16 frees at most one top byte per pass.
                if ((idx_reg == top_idx) && (quot == '0) && (len_reg > LEN_BITS'(1)))
                    len_next = len_reg - LEN_BITS'(1);
                if (pass_end)
                begin
                    count_next = count_reg + CNT_BITS'(1);
                    rem_next   = '0;
                    qnz_next   = 1'b0;
                    idx_next   = IDX_BITS'(len_next - LEN_BITS'(1));
                    if (!qnz_reg && (quot == '0))
                    begin
                        ptr_next   = count_reg[ADR_BITS-1:0];
                        state_next = ST_EMIT_READ;
                    end
                end
                else
                begin
                    rem_next = rem_out;
                    qnz_next = qnz_reg || (quot != '0);
                    idx_next = idx_reg - IDX_BITS'(1);
                end
            end
            ST_EMIT_READ:
            begin
                state_next = ST_EMIT_SHOW;
            end
            ST_EMIT_SHOW:
            begin
                if (!digit_stall)
                begin
                    if (ptr_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        ptr_next   = ptr_reg - ADR_BITS'(1);
                        state_next = ST_EMIT_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            len_reg   <= LEN_BITS'(1);
            count_reg <= '0;
            ptr_reg   <= '0;
            qnz_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            qnz_reg   <= qnz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
    end

    // Digits are written least significant first and read back in reverse.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[count_reg[ADR_BITS-1:0]] <= rem_out;
        if (state_reg == ST_EMIT_READ)
            rd_digit_reg <= digit_mem[ptr_reg];
    end

endmodule
`default_nettype wire

// ----- hdl/rde_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radix digit emitter checker
// Port-level assertions on the item and digit channels, bound to the top.
// ----------------------------------------------------------------------------
module rde_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            item_valid,
    input wire logic                            item_stall,
    input wire logic                            digit_valid,
    input wire logic                            digit_stall,
    input wire logic [rde_pkg::SYMBOL_BITS-1:0] symbol,
    input wire logic                            final_digit
);

    // An accepted beat keeps the block busy until its characters are out.
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall && !digit_valid)
        else $error("block took a new item or showed a digit right after accepting");

    // No new value is taken while characters are still being delivered.
    a_no_item_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> item_stall)
        else $error("input open while a digit beat is pending");

    // Nothing follows the flagged last character.
    a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !digit_stall && final_digit |=> !digit_valid && !item_stall)
        else $error("digit beat after the final digit");

    a_digit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit_stall |=> digit_valid && $stable(symbol)
            && $stable(final_digit))
        else $error("stalled digit beat changed");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .symbol      (symbol),
    .final_digit (final_digit)
);
`default_nettype wire
